### design/trta_pkg.sv
// Shared types, character codes and the fraction digit table for the
// temperature-word-to-ASCII converter. No dependencies.
package trta_pkg;

    localparam int unsigned WordWidth  = 16;
    localparam int unsigned CharWidth  = 7;
    localparam int unsigned WholeWidth = 9;
    localparam int unsigned FracWidth  = 14;
    localparam int unsigned TextLen    = 9;
    localparam int unsigned IdxWidth   = 4;
    localparam int unsigned InBytes    = 2;
    localparam int unsigned OutBytes   = 4;

    localparam logic [CharWidth-1:0] CharCr    = 7'h0D;
    localparam logic [CharWidth-1:0] CharMinus = 7'h2D;
    localparam logic [CharWidth-1:0] CharPoint = 7'h2E;
    localparam logic [CharWidth-1:0] CharSpace = 7'h20;
    localparam logic [CharWidth-1:0] CharZero  = 7'h30;

    // Index of the final beat of a line: the carriage return plus nine text beats.
    localparam logic [IdxWidth-1:0] LastIdx = 4'd9;

    typedef logic [TextLen-1:0][CharWidth-1:0] text_t;

    typedef struct packed {
        text_t                 text;
        logic                  is_negative;
        logic [WholeWidth-1:0] whole_magnitude;
        logic [FracWidth-1:0]  fraction_ten_thousandths;
    } line_t;

    // Four BCD digits of sixteenths times 625, most significant digit on top.
    function automatic logic [15:0] frac_digits(input logic [3:0] sixteenths);
        logic [15:0] bcd;
        unique case (sixteenths)
            4'd0:  bcd = 16'h0000;
            4'd1:  bcd = 16'h0625;
            4'd2:  bcd = 16'h1250;
            4'd3:  bcd = 16'h1875;
            4'd4:  bcd = 16'h2500;
            4'd5:  bcd = 16'h3125;
            4'd6:  bcd = 16'h3750;
            4'd7:  bcd = 16'h4375;
            4'd8:  bcd = 16'h5000;
            4'd9:  bcd = 16'h5625;
            4'd10: bcd = 16'h6250;
            4'd11: bcd = 16'h6875;
            4'd12: bcd = 16'h7500;
            4'd13: bcd = 16'h8125;
            4'd14: bcd = 16'h8750;
            4'd15: bcd = 16'h9375;
            default: bcd = 16'h0000;
        endcase
        return bcd;
    endfunction

endpackage

### design/trta_convert.sv
// Combinational conversion of one raw temperature word into a line of text
// plus sign, magnitude and fraction. Depends on trta_pkg.
module trta_convert (
    input  logic [trta_pkg::WordWidth-1:0] raw_reading,
    output trta_pkg::line_t                line
);

    logic                                ext;
    logic                                neg;
    logic [9:0]                          ipart;
    logic [3:0]                          sixteenths;
    logic [3:0]                          frac_idx;
    logic [9:0]                          whole_wide;
    logic [trta_pkg::WholeWidth-1:0]     whole;
    logic [1:0]                          hund;
    logic [6:0]                          rem;
    logic [13:0]                         tens_prod;
    logic [3:0]                          tens;
    logic [6:0]                          tens_x10;
    logic [3:0]                          ones;
    logic [15:0]                         fbcd;
    logic [3:0]                          n;
    trta_pkg::text_t                     text;

    always_comb begin
        ext  = raw_reading[0];
        neg  = raw_reading[15];
        if (ext) begin
            ipart      = {1'b0, raw_reading[15:7]};
            sixteenths = raw_reading[6:3];
        end else begin
            ipart      = {2'b00, raw_reading[15:8]};
            sixteenths = raw_reading[7:4];
        end

        // A negative value borrows one degree when the fraction is nonzero.
        if (neg) begin
            whole_wide = (ext ? 10'd512 : 10'd256) - ipart
                         - {9'd0, (sixteenths != 4'd0)};
            frac_idx   = 4'(-sixteenths);
        end else begin
            whole_wide = ipart;
            frac_idx   = sixteenths;
        end
        whole = whole_wide[trta_pkg::WholeWidth-1:0];

        if (whole >= 9'd200) begin
            hund = 2'd2;
            rem  = 7'(whole - 9'd200);
        end else if (whole >= 9'd100) begin
            hund = 2'd1;
            rem  = 7'(whole - 9'd100);
        end else begin
            hund = 2'd0;
            rem  = 7'(whole);
        end
        // Exact tens digit for values below 100 via reciprocal multiply.
        tens_prod = 14'(rem) * 14'd103;
        tens      = tens_prod[13:10];
        tens_x10  = 7'({3'd0, tens} * 7'd10);
        ones      = 4'(rem - tens_x10);

        fbcd = trta_pkg::frac_digits(frac_idx);

        for (int i = 0; i < trta_pkg::TextLen; i++) begin
            text[i] = trta_pkg::CharSpace;
        end
        n = 4'd0;
        if (neg) begin
            text[n] = trta_pkg::CharMinus;
            n       = n + 4'd1;
        end
        if (hund != 2'd0) begin
            text[n] = trta_pkg::CharZero + 7'(hund);
            n       = n + 4'd1;
        end
        if (hund != 2'd0 || tens != 4'd0) begin
            text[n] = trta_pkg::CharZero + 7'(tens);
            n       = n + 4'd1;
        end
        text[n]        = trta_pkg::CharZero + 7'(ones);
        text[n + 4'd1] = trta_pkg::CharPoint;
        text[n + 4'd2] = trta_pkg::CharZero + 7'(fbcd[15:12]);
        text[n + 4'd3] = trta_pkg::CharZero + 7'(fbcd[11:8]);
        text[n + 4'd4] = trta_pkg::CharZero + 7'(fbcd[7:4]);
        text[n + 4'd5] = trta_pkg::CharZero + 7'(fbcd[3:0]);

        line.text                     = text;
        line.is_negative              = neg;
        line.whole_magnitude          = whole;
        line.fraction_ten_thousandths = 14'({10'd0, frac_idx} * 14'd625);
    end

endmodule

### design/temp_reading_to_ascii_top.sv
// Top level of the temperature-word-to-ASCII converter: input holding register,
// line register and character serializer. Depends on trta_pkg and trta_convert.
//
// Usage:
//   The slave channel (s_tvalid, s_tready, s_tdata) takes one raw 16-bit
//   thermometer word per beat. Bit 0 of the word picks the 13-bit extended
//   format, otherwise the 12-bit format is used.
//   The master channel (m_tvalid, m_tready, m_tdata, m_tlast) sends ten beats
//   per word: a carriage return, then nine text characters. m_tlast marks the
//   tenth beat. Every beat also carries the sign, the whole magnitude and the
//   fraction in ten-thousandths of the word it belongs to.
//   A word accepted into the input register is converted into the line register
//   once that is empty or its last beat leaves; its carriage return then follows.
//   The serializer sends one character per beat. A second word is held in
//   the input register while a line is still going out, and moves into the
//   line register in the same cycle the last beat of the previous line is
//   taken, so lines follow with no gap.
//   When the receiver stalls, the current beat holds and s_tready drops once
//   the input register is full. Reset (aresetn low at a clock edge) empties
//   both registers and discards any line in progress.
module temp_reading_to_ascii_top (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [15:0] raw_reading
    input  logic [trta_pkg::InBytes*8-1:0] s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [6:0] text_char, [7] is_negative, [16:8] whole_magnitude,
    // [30:17] fraction_ten_thousandths, [31] zero
    output logic [trta_pkg::OutBytes*8-1:0] m_tdata,
    output logic                           m_tlast
);

    logic                               hold_valid_reg;
    logic                               hold_valid_next;
    logic [trta_pkg::WordWidth-1:0]     hold_word_reg;
    logic                               line_valid_reg;
    logic                               line_valid_next;
    trta_pkg::line_t                    line_reg;
    trta_pkg::line_t                    conv_line;
    logic [trta_pkg::IdxWidth-1:0]      idx_reg;
    logic [trta_pkg::IdxWidth-1:0]      idx_next;
    logic                               s_beat;
    logic                               m_beat;
    logic                               line_done;
    logic                               line_load;
    logic [trta_pkg::IdxWidth-1:0]      text_idx;
    logic [trta_pkg::CharWidth-1:0]     text_char;

    trta_convert u_convert (
        .raw_reading (hold_word_reg),
        .line        (conv_line)
    );

    assign s_tready  = !hold_valid_reg;
    assign s_beat    = s_tvalid && s_tready;
    assign m_beat    = m_tvalid && m_tready;
    assign line_done = m_beat && (idx_reg == trta_pkg::LastIdx);
    // The line register takes the held word when empty or when its last beat leaves.
    assign line_load = hold_valid_reg && (!line_valid_reg || line_done);

    always_comb begin
        hold_valid_next = hold_valid_reg;
        if (line_load) begin
            hold_valid_next = 1'b0;
        end else if (s_beat) begin
            hold_valid_next = 1'b1;
        end

        line_valid_next = line_valid_reg;
        idx_next        = idx_reg;
        if (line_load) begin
            line_valid_next = 1'b1;
            idx_next        = '0;
        end else if (line_done) begin
            line_valid_next = 1'b0;
            idx_next        = '0;
        end else if (m_beat) begin
            idx_next = idx_reg + 4'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
            line_valid_reg <= 1'b0;
            idx_reg        <= '0;
        end else begin
            hold_valid_reg <= hold_valid_next;
            line_valid_reg <= line_valid_next;
            idx_reg        <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_beat) begin
            hold_word_reg <= s_tdata[trta_pkg::WordWidth-1:0];
        end
        if (line_load) begin
            line_reg <= conv_line;
        end
    end

    // Beat zero is the carriage return; beats one to nine walk the text.
    always_comb begin
        text_idx = idx_reg - 4'd1;
        if (idx_reg == '0) begin
            text_char = trta_pkg::CharCr;
        end else begin
            text_char = line_reg.text[text_idx];
        end
    end

    assign m_tvalid = line_valid_reg;
    assign m_tlast  = (idx_reg == trta_pkg::LastIdx);
    assign m_tdata  = {1'b0,
                       line_reg.fraction_ten_thousandths,
                       line_reg.whole_magnitude,
                       line_reg.is_negative,
                       text_char};

endmodule

### tb/sv/tb_temp_reading_to_ascii_top.sv
// Self-checking testbench for temp_reading_to_ascii_top: random and directed
// thermometer words in, ten-character text lines checked beat by beat.
// Depends on trta_pkg and the design sources under design/.
`timescale 1ns / 100ps

module tb_temp_reading_to_ascii_top;

    // One output beat as the block should send it.
    typedef struct {
        logic [trta_pkg::CharWidth-1:0]  ch;
        logic                            last;
        logic                            neg;
        logic [trta_pkg::WholeWidth-1:0] whole;
        logic [trta_pkg::FracWidth-1:0]  frac;
    } char_beat_t;

    // One word waiting to be offered, with the idle cycles that precede it and
    // a flag that holds it back until every earlier line has been received.
    typedef struct {
        logic [trta_pkg::WordWidth-1:0] word;
        int unsigned                    gap;
        bit                             after_drain;
    } reading_item_t;

    logic                             aclk     = 1'b0;
    logic                             aresetn  = 1'b0;
    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    logic [trta_pkg::InBytes*8-1:0]   s_tdata  = '0;
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    logic [trta_pkg::OutBytes*8-1:0]  m_tdata;
    logic                             m_tlast;

    reading_item_t readings_to_send[$];
    char_beat_t    line_chars_due[$];
    reading_item_t cur_reading;

    // Handshake flags taken at the rising edge and used at the next falling edge.
    bit          in_taken       = 1'b0;
    bit          out_taken      = 1'b0;
    bit          rx_hold        = 1'b0;
    int unsigned send_gap       = 0;
    int unsigned rx_wait        = 0;
    int unsigned words_accepted = 0;
    int unsigned beats_received = 0;
    int unsigned mismatch_count = 0;

    temp_reading_to_ascii_top u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #4 aclk = ~aclk;

    function automatic logic [trta_pkg::CharWidth-1:0] ascii_digit(input int unsigned d);
        return trta_pkg::CharZero + 7'(d % 10);
    endfunction

    // Works out the ten beats that one thermometer word turns into and appends
    // them to the queue of beats still to come.
    function automatic void queue_line_chars(input logic [trta_pkg::WordWidth-1:0] word);
        int unsigned                    ipart;
        int unsigned                    sixteenths;
        int unsigned                    span;
        int unsigned                    whole;
        int unsigned                    frac;
        int unsigned                    hund;
        int unsigned                    tens;
        int                             n;
        logic                           neg;
        logic [trta_pkg::CharWidth-1:0] text [trta_pkg::TextLen];
        char_beat_t                     beat;

        neg = word[15];
        // Bit 0 picks the extended 13-bit form; the low bits below the
        // sixteenths carry nothing in either form.
        if (word[0]) begin
            ipart      = 32'(word[15:7]);
            sixteenths = 32'(word[6:3]);
            span       = 512;
        end else begin
            ipart      = 32'(word[15:8]);
            sixteenths = 32'(word[7:4]);
            span       = 256;
        end

        // A negative word becomes sign and magnitude. Any nonzero fraction
        // borrows one whole degree; a whole negative value keeps fraction 0.
        if (neg) begin
            whole = span - ipart;
            frac  = 0;
            if (sixteenths != 0) begin
                whole = whole - 1;
                frac  = (16 - sixteenths) * 625;
            end
        end else begin
            whole = ipart;
            frac  = sixteenths * 625;
        end

        n = 0;
        if (neg) begin
            text[n] = trta_pkg::CharMinus;
            n++;
        end
        hund = (whole / 100) % 10;
        tens = (whole / 10) % 10;
        // Leading zeros of the whole part are suppressed, the ones digit is not.
        if (hund != 0) begin
            text[n]     = ascii_digit(hund);
            text[n + 1] = ascii_digit(tens);
            n += 2;
        end else if (tens != 0) begin
            text[n] = ascii_digit(tens);
            n++;
        end
        text[n]     = ascii_digit(whole);
        text[n + 1] = trta_pkg::CharPoint;
        text[n + 2] = ascii_digit(frac / 1000);
        text[n + 3] = ascii_digit(frac / 100);
        text[n + 4] = ascii_digit(frac / 10);
        text[n + 5] = ascii_digit(frac);
        n += 6;
        while (n < int'(trta_pkg::TextLen)) begin
            text[n] = trta_pkg::CharSpace;
            n++;
        end

        beat.neg   = neg;
        beat.whole = whole[trta_pkg::WholeWidth-1:0];
        beat.frac  = frac[trta_pkg::FracWidth-1:0];
        beat.ch    = trta_pkg::CharCr;
        beat.last  = 1'b0;
        line_chars_due.push_back(beat);
        for (int k = 0; k < int'(trta_pkg::TextLen); k++) begin
            beat.ch   = text[k];
            beat.last = (k == int'(trta_pkg::TextLen) - 1);
            line_chars_due.push_back(beat);
        end
    endfunction

    // Compares one received beat with the oldest beat still due.
    function automatic void check_char_beat(input logic [trta_pkg::OutBytes*8-1:0] data,
                                            input logic last);
        char_beat_t due;

        if (line_chars_due.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("ERROR: beat with nothing due: tdata=%h tlast=%b", data, last);
            return;
        end
        due = line_chars_due.pop_front();
        if (data[6:0] != due.ch || data[7] != due.neg || data[16:8] != due.whole ||
            data[30:17] != due.frac || data[31] != 1'b0 || last != due.last) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
                $display("ERROR: beat %0d: expected char=%h neg=%b whole=%0d frac=%0d last=%b",
                         beats_received, due.ch, due.neg, due.whole, due.frac, due.last);
                $display("       got char=%h neg=%b whole=%0d frac=%0d pad=%b last=%b",
                         data[6:0], data[7], data[16:8], data[30:17], data[31], last);
            end
        end
    endfunction

    // Monitor: both channels are sampled at the rising edge. Every accepted
    // word is turned into its ten expected beats, every received beat checked.
    always @(posedge aclk) begin
        in_taken  = aresetn && s_tvalid && s_tready;
        out_taken = aresetn && m_tvalid && m_tready;
        if (out_taken) begin
            check_char_beat(m_tdata, m_tlast);
            beats_received++;
        end
        if (in_taken) begin
            queue_line_chars(s_tdata[trta_pkg::WordWidth-1:0]);
            words_accepted++;
        end
    end

    // Driver: the slave side changes only at the falling edge. A word stays
    // offered until it is taken, then the next one follows after its gap.
    always @(negedge aclk) begin
        if (aresetn && (!s_tvalid || in_taken)) begin
            if (send_gap != 0) begin
                send_gap = send_gap - 1;
                s_tvalid <= 1'b0;
            end else if (readings_to_send.size() != 0 &&
                         !(readings_to_send[0].after_drain && line_chars_due.size() != 0)) begin
                cur_reading = readings_to_send.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= cur_reading.word;
                send_gap = (readings_to_send.size() != 0) ? readings_to_send[0].gap : 0;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: after each beat it takes, it may hold m_tready low for a random stall,
    // with every other stretch of 300 beats free of stalls.
    always @(negedge aclk) begin
        if (out_taken)
            rx_wait = ((beats_received / 300) % 2 == 1) ? 0 : $urandom_range(0, 9);
        if (rx_hold) begin
            m_tready <= 1'b0;
        end else if (rx_wait != 0) begin
            rx_wait = rx_wait - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Long receiver hold-off in the middle of the random part. The sender keeps
    // offering words, so the line and input registers fill and s_tready drops.
    initial begin
        while (words_accepted < 80)
            @(negedge aclk);
        @(posedge aclk);
        rx_hold = 1'b1;
        repeat (150) @(posedge aclk);
        rx_hold = 1'b0;
    end

    // Watchdog: stops the run if the regression hangs.
    initial begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        logic [trta_pkg::WordWidth-1:0] directed_words [];
        reading_item_t                  item;
        int unsigned                    n_random;

        directed_words = '{
            16'h0000,   // 12-bit zero
            16'h0001,   // extended zero
            16'hFFFF,   // all ones, extended: minus one sixteenth
            16'hFFF0,   // all ones in the 12-bit form
            16'h8000,   // most negative 12-bit value, whole
            16'h8001,   // most negative extended value, magnitude 256
            16'h7FF0,   // largest 12-bit value
            16'h7FF9,   // largest extended value
            16'h7FFE,   // 12-bit form with every ignored bit set
            16'h0C87,   // extended 25 degrees with ignored bits set
            16'h0010,   // one sixteenth, single digit
            16'h0A00,   // ten, tens digit without hundreds
            16'h1900,   // 25.0000
            16'h6400,   // one hundred, both upper digits
            16'h6481,   // extended 201.0000, zero tens digit
            16'hE700,   // negative whole value, no borrow
            16'hE740,   // negative with a borrow
            16'hFF40,   // negative below one degree
            16'hFFF9,   // extended negative below one degree
            16'h9C01,   // extended negative whole value
            16'h5A5A,   // alternating bit patterns
            16'hA5A5
        };
        n_random = 250;
        foreach (directed_words[i]) begin
            item.word        = directed_words[i];
            item.gap         = $urandom_range(0, 9);
            item.after_drain = 1'b0;
            readings_to_send.push_back(item);
        end

        // Random part: uniform words, values near zero of either sign, and
        // whole-degree values that take the no-borrow path when negative.
        for (int i = 0; i < n_random; i++) begin
            case ($urandom_range(0, 3))
                0, 1: item.word = 16'($urandom_range(0, 65535));
                2: item.word = 16'($urandom_range(0, 1023)) - 16'd512;
                default: begin
                    item.word = 16'($urandom_range(0, 65535));
                    if (item.word[0])
                        item.word[6:3] = 4'd0;
                    else
                        item.word[7:4] = 4'd0;
                end
            endcase
            // Sender gaps come in stretches of 40 words, every other one without.
            item.gap         = ((i / 40) % 2 == 1) ? 0 : $urandom_range(0, 9);
            item.after_drain = (i == 0 || i == 130 || i == 200);
            readings_to_send.push_back(item);
        end

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (readings_to_send.size() != 0 || s_tvalid || line_chars_due.size() != 0)
            @(posedge aclk);
        // Any stray beat after the last line still gets caught here.
        repeat (30) @(posedge aclk);

        if (mismatch_count == 0 && line_chars_due.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

### sim.f
design/trta_pkg.sv
design/trta_convert.sv
design/temp_reading_to_ascii_top.sv
tb/sv/tb_temp_reading_to_ascii_top.sv
